// ===== rtl/core/iir_bandpass_two_pole_core_assert.svh =====
// assertion macros used by the band-pass filter checker
`ifndef IIR_BANDPASS_TWO_POLE_CORE_ASSERT_SVH
`define IIR_BANDPASS_TWO_POLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define IIRBP_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("iirbp check failed");

// next-cycle implication, disabled while reset is low
`define IIRBP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("iirbp check failed");

`endif

// ===== rtl/core/iirbp_pkg.sv =====
// types and fixed constants of the two-pole band-pass filter
package iirbp_pkg;

	localparam int CUTOFF_W  = 16;
	localparam int COEF_W    = 16;
	localparam int FRAC_BITS = 14;

	localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 16'h8000;
	localparam logic [CUTOFF_W-1:0] BYPASS_ABOVE = 16'd32735;

	// 1.8647010906 and -0.8667884395 in Q2.14
	localparam logic signed [COEF_W-1:0] COEF_A = 16'sd30551;
	localparam logic signed [COEF_W-1:0] COEF_B = -16'sd14201;

	// feedback coefficient: A + floor((FB_HALF - FB_SLOPE * cutoff) / 163840)
	localparam int SLOPE_W = 17;
	localparam int PROD_W  = SLOPE_W + CUTOFF_W;
	localparam logic [SLOPE_W-1:0] FB_SLOPE = 17'd91653;
	localparam logic signed [PROD_W+1:0] FB_HALF = 35'sd81920;
	// 163840 = 32768 * 5: shift by 15, then divide by 5 via reciprocal
	localparam int DEN_SHIFT = 15;
	localparam int QUOT_W    = 18;
	localparam logic [QUOT_W-1:0] DIV5_OFFSET = 18'd200000;
	// A minus the 40000 that the offset adds to the quotient
	localparam logic signed [COEF_W-1:0] DIV5_OFFSET_Q = COEF_W'(int'(COEF_A) - 40000);
	localparam int RECIP_W     = 19;
	localparam int RECIP_SHIFT = 21;
	localparam logic [RECIP_W-1:0] RECIP5 = 19'd419431;

	typedef struct packed {
		logic                       busy;
		logic                       bypass;
		logic signed [COEF_W-1:0]   fb;
	} coef_t;

endpackage

// ===== rtl/core/iir_bandpass_two_pole_core.sv =====
// Two-pole band-pass filter core. One sample item is accepted per clock unless src_stall holds
// the input, and the filtered (or, with cutoff above 32735, passed-through) sample reaches the
// output through an input register and an output register; the whole recurrence, with its two
// parallel multiplies, sits between them, so throughput is one item per cycle while nothing
// stalls. A write to the cutoff register stalls the input for the write cycle and while the
// feedback coefficient is rebuilt by its two registered multiply stages.
module iir_bandpass_two_pole_core #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           src_valid,
	output logic                           src_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	output logic                           dst_valid,
	input  logic                           dst_stall,
	output logic signed [SAMPLE_WIDTH-1:0] sample_out,
	input  logic                           cfg_we,
	input  logic [iirbp_pkg::CUTOFF_W-1:0] cfg_wdata
);

	iirbp_pkg::coef_t              coef;
	logic                          valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] x_s1;
	logic                          dst_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
	logic signed [SAMPLE_WIDTH-1:0] y_filt;
	logic                          advance;
	logic                          src_take;

	iirbp_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.coef      (coef)
	);

	iirbp_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.STATE_WIDTH  (STATE_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.update (advance && valid_s1 && !coef.bypass),
		.x      (x_s1),
		.fb     (coef.fb),
		.y_out  (y_filt)
	);

	// output register empty or draining this cycle
	assign advance   = !dst_valid_q || !dst_stall;
	assign src_stall = coef.busy || (valid_s1 && !advance);
	assign src_take  = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			dst_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				dst_valid_q <= valid_s1;
			end
			if (src_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_take) begin
			x_s1 <= sample_in;
		end
		if (advance && valid_s1) begin
			sample_out_q <= coef.bypass ? x_s1 : y_filt;
		end
	end

	assign dst_valid  = dst_valid_q;
	assign sample_out = sample_out_q;

endmodule

// ===== rtl/core/iirbp_coef.sv =====
// cutoff register and two-stage feedback coefficient pipeline
module iirbp_coef (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iirbp_pkg::CUTOFF_W-1:0] cfg_wdata,
	output iirbp_pkg::coef_t               coef
);

	logic [iirbp_pkg::CUTOFF_W-1:0]        cutoff_q;
	logic [1:0]                            busy_q;
	logic [iirbp_pkg::PROD_W-1:0]          prod_s1;
	logic signed [iirbp_pkg::COEF_W-1:0]   fb_s2;
	logic signed [iirbp_pkg::PROD_W+1:0]   num;
	logic signed [iirbp_pkg::PROD_W+1-iirbp_pkg::DEN_SHIFT:0] num_hi;
	logic [iirbp_pkg::QUOT_W-1:0]          num_off;
	logic [iirbp_pkg::QUOT_W+iirbp_pkg::RECIP_W-1:0] quot_full;
	logic signed [iirbp_pkg::COEF_W-1:0]   quot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q <= iirbp_pkg::CUTOFF_RESET;
			busy_q   <= 2'd0;
		end else begin
			if (cfg_we) begin
				cutoff_q <= cfg_wdata;
				busy_q   <= 2'd2;
			end else if (busy_q != 2'd0) begin
				busy_q <= busy_q - 2'd1;
			end
		end
	end

	// floor division by 163840 after the slope product
	always_comb begin
		num       = iirbp_pkg::FB_HALF - $signed({2'b00, prod_s1});
		num_hi    = num[iirbp_pkg::PROD_W+1:iirbp_pkg::DEN_SHIFT];
		num_off   = iirbp_pkg::QUOT_W'(num_hi) + iirbp_pkg::DIV5_OFFSET;
		quot_full = {{iirbp_pkg::RECIP_W{1'b0}}, num_off}
			* {{iirbp_pkg::QUOT_W{1'b0}}, iirbp_pkg::RECIP5};
		quot      = $signed(iirbp_pkg::COEF_W'(quot_full >> iirbp_pkg::RECIP_SHIFT));
	end

	always_ff @(posedge clk) begin
		prod_s1 <= {{iirbp_pkg::CUTOFF_W{1'b0}}, iirbp_pkg::FB_SLOPE}
			* {{iirbp_pkg::SLOPE_W{1'b0}}, cutoff_q};
		fb_s2   <= quot + iirbp_pkg::DIV5_OFFSET_Q;
	end

	assign coef.busy   = cfg_we || (busy_q != 2'd0);
	assign coef.bypass = cutoff_q > iirbp_pkg::BYPASS_ABOVE;
	assign coef.fb     = fb_s2;

endmodule

// ===== rtl/core/iirbp_datapath.sv =====
// filter recurrence, history registers and saturation
module iirbp_datapath #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 20
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  update,
	input  logic signed [SAMPLE_WIDTH-1:0]        x,
	input  logic signed [iirbp_pkg::COEF_W-1:0]   fb,
	output logic signed [SAMPLE_WIDTH-1:0]        y_out
);

	localparam int XS_W  = SAMPLE_WIDTH - 2;
	localparam int PW    = STATE_WIDTH + iirbp_pkg::COEF_W;
	localparam int ACC_A = STATE_WIDTH + 18;
	localparam int ACC_B = SAMPLE_WIDTH + 15;
	localparam int ACC_W = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int RW    = ACC_W - iirbp_pkg::FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (iirbp_pkg::FRAC_BITS - 1);

	logic signed [XS_W-1:0]        xh0_q, xh1_q;
	logic signed [STATE_WIDTH-1:0] yh0_q, yh1_q;
	logic signed [XS_W-1:0]        xs;
	logic signed [XS_W:0]          diff;
	logic signed [PW-1:0]          prod_b, prod_f;
	logic signed [ACC_W-1:0]       acc;
	logic signed [RW-1:0]          r;
	logic signed [STATE_WIDTH-1:0] y;
	logic                          r_fits;

	always_comb begin
		xs     = x[SAMPLE_WIDTH-1:2];
		diff   = $signed({xs[XS_W-1], xs}) - $signed({xh0_q[XS_W-1], xh0_q});
		prod_b = PW'(iirbp_pkg::COEF_B) * PW'(yh0_q);
		prod_f = PW'(fb) * PW'(yh1_q);
		acc    = (ACC_W'(diff) <<< iirbp_pkg::FRAC_BITS) + ACC_W'(prod_b)
			+ ACC_W'(prod_f) + ROUND_HALF;
		r      = acc[ACC_W-1:iirbp_pkg::FRAC_BITS];
		r_fits = (&r[RW-1:STATE_WIDTH-1]) || !(|r[RW-1:STATE_WIDTH-1]);
		if (r_fits) begin
			y = r[STATE_WIDTH-1:0];
		end else if (r[RW-1]) begin
			y = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		end else begin
			y = {1'b0, {(STATE_WIDTH-1){1'b1}}};
		end
	end

	generate
		if (SAMPLE_WIDTH >= STATE_WIDTH) begin : g_out_wide
			assign y_out = SAMPLE_WIDTH'(y);
		end else begin : g_out_narrow
			logic y_fits;
			assign y_fits = (&y[STATE_WIDTH-1:SAMPLE_WIDTH-1])
				|| !(|y[STATE_WIDTH-1:SAMPLE_WIDTH-1]);
			assign y_out = y_fits ? y[SAMPLE_WIDTH-1:0]
				: (y[STATE_WIDTH-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
				: {1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xh0_q <= '0;
			xh1_q <= '0;
			yh0_q <= '0;
			yh1_q <= '0;
		end else if (update) begin
			xh0_q <= xh1_q;
			xh1_q <= xs;
			yh0_q <= yh1_q;
			yh1_q <= y;
		end
	end

endmodule

// ===== rtl/core/iirbp_checker.sv =====
// port-level checks of the band-pass filter core, bound to the top level
`include "iir_bandpass_two_pole_core_assert.svh"

module iirbp_checker #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    src_valid,
	input logic                    src_stall,
	input logic                    dst_valid,
	input logic                    dst_stall,
	input logic [SAMPLE_WIDTH-1:0] sample_out,
	input logic                    cfg_we
);

	// a stalled result item holds
	`IIRBP_ASSERT_NEXT(a_dst_hold, clk, arst_n, dst_valid && dst_stall, dst_valid && $stable(sample_out))

	// coefficient rebuild blocks new items after a cutoff write
	`IIRBP_ASSERT_NEXT(a_cfg_stall, clk, arst_n, cfg_we, src_stall)

	// an accepted item moves from the input register into an empty output register
	`IIRBP_ASSERT_NEXT(a_latency, clk, arst_n, (src_valid && !src_stall) ##1 !dst_valid, dst_valid)

	// a result item only appears after an accepted item has passed the input register
	`IIRBP_ASSERT_NOW(a_no_invent, clk, arst_n, $rose(dst_valid), $past(src_valid && !src_stall, 2))

endmodule

bind iir_bandpass_two_pole_core iirbp_checker #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_iirbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.src_valid  (src_valid),
	.src_stall  (src_stall),
	.dst_valid  (dst_valid),
	.dst_stall  (dst_stall),
	.sample_out (sample_out),
	.cfg_we     (cfg_we)
);

// ===== dv/testbench.sv =====
// self-checking testbench for the two-pole band-pass filter core
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  PERIOD_HALF  = 10;
	localparam int  HOLD_CYCLES  = 80;
	localparam int  SETTLE       = 6;
	localparam int  PHASE_ITEMS  = 120;
	localparam longint A_Q14     = 30551;
	localparam longint B_Q14     = -14201;
	localparam longint FB_SCALE  = 163840;
	localparam logic [15:0] PASS_LIMIT = 16'd32735;
	localparam longint Y_MAX     = 524287;
	localparam longint Y_MIN     = -524288;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               src_valid = 1'b0;
	logic               src_stall;
	logic signed [15:0] sample_in = '0;
	logic               dst_valid;
	logic               dst_stall = 1'b0;
	logic signed [15:0] sample_out;
	logic               cfg_we = 1'b0;
	logic [iirbp_pkg::CUTOFF_W-1:0] cfg_wdata = '0;

	// filter state as seen by the predictor
	logic [15:0]        cutoff_q = 16'h8000;
	logic signed [15:0] x_hist [2] = '{16'sd0, 16'sd0};
	logic signed [19:0] y_hist [2] = '{20'sd0, 20'sd0};

	logic signed [15:0] pending_samples [$];
	logic signed [15:0] expected_samples [$];
	int                 error_count = 0;
	bit                 idle_on = 1'b1;
	bit                 hold_start = 1'b0;
	bit                 hold_done = 1'b0;
	int                 hold_left = 0;
	int                 stall_left = 0;
	int                 src_gap = 0;

	iir_bandpass_two_pole_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.src_valid  (src_valid),
		.src_stall  (src_stall),
		.sample_in  (sample_in),
		.dst_valid  (dst_valid),
		.dst_stall  (dst_stall),
		.sample_out (sample_out),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#PERIOD_HALF clk = 1'b1;
		#PERIOD_HALF clk = 1'b0;
	end

	function automatic logic signed [15:0] bandpass_predict(input logic signed [15:0] x);
		logic signed [15:0] xs;
		longint fb;
		longint acc;
		longint y;
		if (cutoff_q > PASS_LIMIT)
			return x;
		xs = x >>> 2;
		fb = (A_Q14 * (FB_SCALE - 3 * longint'(cutoff_q)) + FB_SCALE / 2) / FB_SCALE;
		acc = (longint'(xs) - longint'(x_hist[0])) * 16384
			+ B_Q14 * longint'(y_hist[0]) + fb * longint'(y_hist[1]);
		y = (acc + 8192) >>> 14;
		if (y > Y_MAX)
			y = Y_MAX;
		else if (y < Y_MIN)
			y = Y_MIN;
		x_hist[0] = x_hist[1];
		x_hist[1] = xs;
		y_hist[0] = y_hist[1];
		y_hist[1] = y[19:0];
		if (y > 32767)
			return 16'sh7fff;
		if (y < -32768)
			return 16'sh8000;
		return y[15:0];
	endfunction

	// sender: holds an item until taken, then optionally pauses
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
			src_gap <= 0;
		end else begin
			if (src_valid && !src_stall)
				expected_samples.push_back(bandpass_predict(sample_in));
			if (!(src_valid && src_stall)) begin
				if (src_gap > 0) begin
					src_gap <= src_gap - 1;
					src_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					src_valid <= 1'b1;
					sample_in <= pending_samples.pop_front();
					if (idle_on && $urandom_range(0, 7) == 0)
						src_gap <= $urandom_range(1, 7);
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall bursts, one long hold-off on request, result checking
	always @(posedge clk or negedge arst_n) begin
		logic signed [15:0] want;
		if (!arst_n) begin
			dst_stall <= 1'b0;
			hold_left <= 0;
			stall_left <= 0;
		end else begin
			if (dst_valid && !dst_stall) begin
				if (expected_samples.size() == 0) begin
					$error("unexpected item: sample_out %0d", sample_out);
					error_count++;
				end else begin
					want = expected_samples.pop_front();
					if (sample_out !== want) begin
						$error("sample_out mismatch: expected %0d, actual %0d", want, sample_out);
						error_count++;
					end
				end
			end
			if (hold_start && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				dst_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				dst_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				dst_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				stall_left <= $urandom_range(0, 6);
				dst_stall <= 1'b1;
			end else begin
				dst_stall <= 1'b0;
			end
		end
	end

	task automatic wait_drained();
		while (pending_samples.size() > 0 || src_valid || expected_samples.size() > 0)
			@(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cutoff(input logic [15:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cutoff_q = value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// random items mixed with square-wave bursts that drive the filter into saturation
	task automatic queue_random(input int count);
		int n;
		int kind;
		int half;
		int periods;
		logic signed [15:0] amp;
		n = 0;
		while (n < count) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				pending_samples.push_back(16'($urandom));
				n++;
			end else if (kind < 8) begin
				case ($urandom_range(0, 3))
					0: pending_samples.push_back(16'sh7fff);
					1: pending_samples.push_back(16'sh8000);
					default: pending_samples.push_back(16'($signed($urandom_range(0, 15)) - 8));
				endcase
				n++;
			end else begin
				half = $urandom_range(1, 40);
				periods = $urandom_range(1, 4);
				amp = $urandom_range(0, 1) ? 16'sh7fff : 16'($urandom_range(1000, 32767));
				for (int p = 0; p < periods; p++) begin
					for (int k = 0; k < half; k++)
						pending_samples.push_back(amp);
					for (int k = 0; k < half; k++)
						pending_samples.push_back(amp == 16'sh7fff ? 16'sh8000 : -amp);
				end
				n += 2 * half * periods;
			end
		end
	endtask

	initial begin
		logic [15:0] phase_cutoff [10];
		phase_cutoff = '{16'd0, 16'd32735, 16'd32736, 16'd65535, 16'd16384,
			16'd1, 16'd32734, 16'($urandom_range(0, 32735)), 16'($urandom), 16'd0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset cutoff is above the pass-through limit
		pending_samples = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1, 16'sd1};
		wait_drained();

		write_cutoff(16'd0);
		// negative odd values check the rounding of the input scaling
		pending_samples = '{16'sh8000, 16'sh7fff, -16'sd1, 16'sd1, -16'sd2, -16'sd3,
			16'sd3, 16'sd0};
		repeat (6) pending_samples.push_back(16'sh7fff);
		repeat (6) pending_samples.push_back(16'sh8000);
		wait_drained();

		for (int ph = 0; ph < 10; ph++) begin
			write_cutoff(phase_cutoff[ph]);
			idle_on = (ph == 9) ? 1'b0 : ($urandom_range(0, 3) != 0);
			queue_random(PHASE_ITEMS);
			if (ph == 3)
				hold_start = 1'b1;
			wait_drained();
		end

		repeat (SETTLE) @(posedge clk);
		if (error_count == 0 && expected_samples.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#4ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
